// File: design/oomvs_pkg.sv
// Shared types and constants for the victim selector.
package oomvs_pkg;

   localparam int IdWidth     = 16;
   localparam int ScoreWidth  = 10;
   localparam int PagesWidth  = 32;
   localparam int TargetWidth = 24;
   localparam int TotalWidth  = 40;

   localparam logic [TargetWidth-1:0] TargetReset = 24'd25600;
   localparam logic [ScoreWidth:0]    ScoreAbove  = 11'd1024;

   typedef struct packed {
      logic [IdWidth-1:0]    id;
      logic [ScoreWidth-1:0] score;
      logic [PagesWidth-1:0] pages;
      logic                  ok;
   } cand_type;

   typedef struct packed {
      logic [IdWidth-1:0]    id;
      logic [ScoreWidth-1:0] score;
      logic [PagesWidth-1:0] pages;
   } victim_type;

   typedef struct packed {
      logic                  load;
      logic [IdWidth-1:0]    id;
      logic [ScoreWidth-1:0] score;
      logic [PagesWidth-1:0] pages;
      logic                  none;
      logic                  last;
   } rsp_load_type;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_SCAN_RD  = 14'b00000000000010,
      ST_SCAN_EV  = 14'b00000000000100,
      ST_INS_RD   = 14'b00000000001000,
      ST_INS_EV   = 14'b00000000010000,
      ST_PASS_END = 14'b00000000100000,
      ST_POST     = 14'b00000001000000,
      ST_CUT_RD   = 14'b00000010000000,
      ST_CUT_EV   = 14'b00000100000000,
      ST_RS_RD    = 14'b00001000000000,
      ST_RS_EV    = 14'b00010000000000,
      ST_EM_RD    = 14'b00100000000000,
      ST_EM_LD    = 14'b01000000000000,
      ST_EM_WAIT  = 14'b10000000000000
   } state_type;

endpackage

// File: design/oom_victim_selector_core.sv
// Top level of the victim selector: register, memories, sequencer and result register.
// Loading accepts one candidate word per cycle while idle; the block is ready again
// after the last result. After the final candidate, each score pass reads every
// stored candidate in turn. Insertion into the victim list moves one position at a
// time, trimming sums one entry at a time, and each result waits for rsp_ready.
// Synchronous reset clears the sequencer, counters and result valid and sets the target to
// 25600; the memories are not cleared.
module oom_victim_selector_core import oomvs_pkg::*; #(
   parameter int MAX_CANDIDATES = 256,
   parameter int MAX_SELECTED   = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [TargetWidth-1:0]      csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [IdWidth-1:0]          req_task_id,
   input  logic signed [ScoreWidth:0]  req_adjust_score,
   input  logic [PagesWidth-1:0]       req_resident_pages,
   input  logic                        req_eligible,
   input  logic                        req_final_candidate,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [IdWidth-1:0]          rsp_victim_id,
   output logic [ScoreWidth-1:0]       rsp_victim_score,
   output logic [PagesWidth-1:0]       rsp_victim_pages,
   output logic                        rsp_none_found,
   output logic                        rsp_last_victim
);

   localparam int CIW = $clog2(MAX_CANDIDATES);
   localparam int VIW = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;

   logic [TargetWidth-1:0] target_ff;
   logic                   rsp_valid_ff;
   logic [IdWidth-1:0]     id_ff;
   logic [ScoreWidth-1:0]  score_ff;
   logic [PagesWidth-1:0]  pages_ff;
   logic                   none_ff, last_ff;

   logic           cand_wr_en, cand_rd_en, vic_wr_en, vic_rd_en;
   logic [CIW-1:0] cand_wr_addr, cand_rd_addr;
   logic [VIW-1:0] vic_wr_addr, vic_rd_addr;
   cand_type       cand_wr_data, cand_rd_data;
   victim_type     vic_wr_data, vic_rd_data;
   rsp_load_type   rsp_load;
   logic           rsp_take;

   assign rsp_take = rsp_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TargetReset;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         id_ff    <= rsp_load.id;
         score_ff <= rsp_load.score;
         pages_ff <= rsp_load.pages;
         none_ff  <= rsp_load.none;
         last_ff  <= rsp_load.last;
      end
   end

   oomvs_ram #(.Width($bits(cand_type)), .Depth(MAX_CANDIDATES)) u_cand_ram (
      .clock   (clock),
      .wr_en   (cand_wr_en),
      .wr_addr (cand_wr_addr),
      .wr_data (cand_wr_data),
      .rd_en   (cand_rd_en),
      .rd_addr (cand_rd_addr),
      .rd_data (cand_rd_data)
   );

   oomvs_ram #(.Width($bits(victim_type)), .Depth(MAX_SELECTED)) u_vic_ram (
      .clock   (clock),
      .wr_en   (vic_wr_en),
      .wr_addr (vic_wr_addr),
      .wr_data (vic_wr_data),
      .rd_en   (vic_rd_en),
      .rd_addr (vic_rd_addr),
      .rd_data (vic_rd_data)
   );

   oomvs_seq #(.MaxCand(MAX_CANDIDATES), .MaxSel(MAX_SELECTED)) u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_task_id         (req_task_id),
      .req_adjust_score    (req_adjust_score),
      .req_resident_pages  (req_resident_pages),
      .req_eligible        (req_eligible),
      .req_final_candidate (req_final_candidate),
      .target              (target_ff),
      .cand_wr_en          (cand_wr_en),
      .cand_wr_addr        (cand_wr_addr),
      .cand_wr_data        (cand_wr_data),
      .cand_rd_en          (cand_rd_en),
      .cand_rd_addr        (cand_rd_addr),
      .cand_rd_data        (cand_rd_data),
      .vic_wr_en           (vic_wr_en),
      .vic_wr_addr         (vic_wr_addr),
      .vic_wr_data         (vic_wr_data),
      .vic_rd_en           (vic_rd_en),
      .vic_rd_addr         (vic_rd_addr),
      .vic_rd_data         (vic_rd_data),
      .rsp_load            (rsp_load),
      .rsp_take            (rsp_take)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_id    = id_ff;
   assign rsp_victim_score = score_ff;
   assign rsp_victim_pages = pages_ff;
   assign rsp_none_found   = none_ff;
   assign rsp_last_victim  = last_ff;

endmodule

// File: design/oomvs_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module oomvs_ram #(
   parameter int Width = 8,
   parameter int Depth = 2,
   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/oomvs_seq.sv
// Sequencer that loads candidates, walks scores, sorts, trims and emits victims.
module oomvs_seq import oomvs_pkg::*; #(
   parameter int MaxCand = 256,
   parameter int MaxSel  = 64,
   localparam int CIW = $clog2(MaxCand),
   localparam int CCW = $clog2(MaxCand + 1),
   localparam int VIW = (MaxSel > 1) ? $clog2(MaxSel) : 1,
   localparam int VCW = $clog2(MaxSel + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [IdWidth-1:0]           req_task_id,
   input  logic signed [ScoreWidth:0]   req_adjust_score,
   input  logic [PagesWidth-1:0]        req_resident_pages,
   input  logic                         req_eligible,
   input  logic                         req_final_candidate,
   input  logic [TargetWidth-1:0]       target,
   output logic                         cand_wr_en,
   output logic [CIW-1:0]               cand_wr_addr,
   output cand_type                     cand_wr_data,
   output logic                         cand_rd_en,
   output logic [CIW-1:0]               cand_rd_addr,
   input  cand_type                     cand_rd_data,
   output logic                         vic_wr_en,
   output logic [VIW-1:0]               vic_wr_addr,
   output victim_type                   vic_wr_data,
   output logic                         vic_rd_en,
   output logic [VIW-1:0]               vic_rd_addr,
   input  victim_type                   vic_rd_data,
   output rsp_load_type                 rsp_load,
   input  logic                         rsp_take
);

   state_type state_ff, state_in;
   logic [CCW-1:0] cand_count_ff, cand_count_in, k_ff, k_in, cnt_next;
   logic [ScoreWidth:0] score_ff, score_in;
   logic [ScoreWidth-1:0] next_ff, next_in;
   logic has_next_ff, has_next_in;
   logic [VCW-1:0] vc_ff, vc_in, seg_ff, seg_in, j_ff, j_in, i_ff, i_in;
   logic [VCW-1:0] n_ff, n_in, lo_ff, lo_in;
   logic tie_ff, tie_in, resort_ff, resort_in, cut2_ff, cut2_in;
   victim_type key_ff, key_in;
   logic [TotalWidth-1:0] total_ff, total_in, sum_ff, sum_in, target_ext;
   logic [CCW-1:0] k_dec;
   logic [VCW-1:0] j_dec, i_inc, vc_inc;
   logic ins_done;

   assign target_ext = {{(TotalWidth-TargetWidth){1'b0}}, target};
   assign k_dec  = k_ff - CCW'(1);
   assign j_dec  = j_ff - VCW'(1);
   assign i_inc  = i_ff + VCW'(1);
   assign vc_inc = vc_ff + VCW'(1);

   always_comb begin
      state_in      = state_ff;
      cand_count_in = cand_count_ff;
      k_in          = k_ff;
      score_in      = score_ff;
      next_in       = next_ff;
      has_next_in   = has_next_ff;
      vc_in         = vc_ff;
      seg_in        = seg_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      n_in          = n_ff;
      lo_in         = lo_ff;
      tie_in        = tie_ff;
      resort_in     = resort_ff;
      cut2_in       = cut2_ff;
      key_in        = key_ff;
      total_in      = total_ff;
      sum_in        = sum_ff;
      ins_done      = 1'b0;
      cnt_next      = cand_count_ff;

      req_ready     = (state_ff == ST_IDLE);
      cand_wr_en    = 1'b0;
      cand_wr_addr  = cand_count_ff[CIW-1:0];
      cand_wr_data.id    = req_task_id;
      cand_wr_data.score = req_adjust_score[ScoreWidth-1:0];
      cand_wr_data.pages = req_resident_pages;
      cand_wr_data.ok    = req_eligible & ~req_adjust_score[ScoreWidth];
      cand_rd_en    = 1'b0;
      cand_rd_addr  = k_dec[CIW-1:0];
      vic_wr_en     = 1'b0;
      vic_wr_addr   = j_ff[VIW-1:0];
      vic_wr_data   = key_ff;
      vic_rd_en     = 1'b0;
      vic_rd_addr   = j_dec[VIW-1:0];
      rsp_load      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (cand_count_ff < CCW'(MaxCand)) begin
                  cand_wr_en = 1'b1;
                  cnt_next   = cand_count_ff + CCW'(1);
               end
               cand_count_in = cnt_next;
               if (req_final_candidate) begin
                  score_in    = ScoreAbove;
                  has_next_in = 1'b0;
                  vc_in       = '0;
                  seg_in      = '0;
                  total_in    = '0;
                  k_in        = cnt_next;
                  resort_in   = 1'b0;
                  state_in    = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (k_ff == '0) begin
               state_in = ST_PASS_END;
            end else begin
               cand_rd_en = 1'b1;
               state_in   = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            k_in = k_dec;
            if (cand_rd_data.ok && ({1'b0, cand_rd_data.score} < score_ff) &&
                (!has_next_ff || cand_rd_data.score > next_ff)) begin
               next_in     = cand_rd_data.score;
               has_next_in = 1'b1;
            end
            if (cand_rd_data.ok && ({1'b0, cand_rd_data.score} == score_ff)) begin
               key_in.id    = cand_rd_data.id;
               key_in.score = cand_rd_data.score;
               key_in.pages = cand_rd_data.pages;
               total_in     = total_ff + {{(TotalWidth-PagesWidth){1'b0}},
                                          cand_rd_data.pages};
               j_in         = vc_ff;
               lo_in        = seg_ff;
               tie_in       = 1'b1;
               state_in     = ST_INS_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_INS_RD: begin
            if (j_ff == lo_ff) begin
               vic_wr_en = 1'b1;
               ins_done  = 1'b1;
            end else begin
               vic_rd_en = 1'b1;
               state_in  = ST_INS_EV;
            end
         end
         ST_INS_EV: begin
            vic_wr_en = 1'b1;
            if ((vic_rd_data.pages < key_ff.pages) ||
                (tie_ff && vic_rd_data.pages == key_ff.pages)) begin
               vic_wr_data = vic_rd_data;
               j_in        = j_dec;
               state_in    = ST_INS_RD;
            end else begin
               ins_done = 1'b1;
            end
         end
         ST_PASS_END: begin
            if ((vc_ff != seg_ff) && (total_ff >= target_ext)) begin
               state_in = ST_POST;
            end else if (has_next_ff) begin
               score_in    = {1'b0, next_ff};
               has_next_in = 1'b0;
               seg_in      = vc_ff;
               k_in        = cand_count_ff;
               state_in    = ST_SCAN_RD;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            i_in = '0;
            if ((vc_ff != '0) && (total_ff > target_ext)) begin
               sum_in   = '0;
               cut2_in  = 1'b0;
               n_in     = vc_ff;
               state_in = ST_CUT_RD;
            end else begin
               state_in = ST_EM_RD;
            end
         end
         ST_CUT_RD: begin
            vic_rd_addr = i_ff[VIW-1:0];
            if ((i_ff == n_ff) || (sum_ff >= target_ext)) begin
               if (!cut2_ff) begin
                  n_in     = i_ff;
                  i_in     = VCW'(1);
                  state_in = ST_RS_RD;
               end else begin
                  vc_in    = i_ff;
                  i_in     = '0;
                  state_in = ST_EM_RD;
               end
            end else begin
               vic_rd_en = 1'b1;
               state_in  = ST_CUT_EV;
            end
         end
         ST_CUT_EV: begin
            sum_in   = sum_ff + {{(TotalWidth-PagesWidth){1'b0}}, vic_rd_data.pages};
            i_in     = i_inc;
            state_in = ST_CUT_RD;
         end
         ST_RS_RD: begin
            vic_rd_addr = i_ff[VIW-1:0];
            if (i_ff >= n_ff) begin
               i_in     = '0;
               sum_in   = '0;
               cut2_in  = 1'b1;
               state_in = ST_CUT_RD;
            end else begin
               vic_rd_en = 1'b1;
               state_in  = ST_RS_EV;
            end
         end
         ST_RS_EV: begin
            key_in    = vic_rd_data;
            j_in      = i_ff;
            lo_in     = '0;
            tie_in    = 1'b0;
            resort_in = 1'b1;
            state_in  = ST_INS_RD;
         end
         ST_EM_RD: begin
            vic_rd_addr = i_ff[VIW-1:0];
            if (vc_ff == '0) begin
               rsp_load.load = 1'b1;
               rsp_load.none = 1'b1;
               rsp_load.last = 1'b1;
               state_in      = ST_EM_WAIT;
            end else begin
               vic_rd_en = 1'b1;
               state_in  = ST_EM_LD;
            end
         end
         ST_EM_LD: begin
            rsp_load.load  = 1'b1;
            rsp_load.id    = vic_rd_data.id;
            rsp_load.score = vic_rd_data.score;
            rsp_load.pages = vic_rd_data.pages;
            rsp_load.last  = (i_inc == vc_ff);
            state_in       = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (rsp_take) begin
               if ((vc_ff == '0) || (i_inc == vc_ff)) begin
                  cand_count_in = '0;
                  vc_in         = '0;
                  total_in      = '0;
                  state_in      = ST_IDLE;
               end else begin
                  i_in     = i_inc;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ins_done) begin
         if (resort_ff) begin
            i_in     = i_inc;
            state_in = ST_RS_RD;
         end else begin
            vc_in = vc_inc;
            if (vc_inc == VCW'(MaxSel)) begin
               state_in = ST_POST;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cand_count_ff <= '0;
         vc_ff         <= '0;
         total_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cand_count_ff <= cand_count_in;
         vc_ff         <= vc_in;
         total_ff      <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      score_ff    <= score_in;
      next_ff     <= next_in;
      has_next_ff <= has_next_in;
      seg_ff      <= seg_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      tie_ff      <= tie_in;
      resort_ff   <= resort_in;
      cut2_ff     <= cut2_in;
      key_ff      <= key_in;
      sum_ff      <= sum_in;
   end

endmodule

// File: design/oomvs_checker.sv
// Port-level assertions for the victim selector and their binding.
module oomvs_checker import oomvs_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_final_candidate,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [IdWidth-1:0]         rsp_victim_id,
   input logic [ScoreWidth-1:0]      rsp_victim_score,
   input logic [PagesWidth-1:0]      rsp_victim_pages,
   input logic                       rsp_none_found,
   input logic                       rsp_last_victim
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_victim_id) &&
      $stable(rsp_victim_pages) && $stable(rsp_last_victim))
      else $error("Stalled result word changed.");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Input ready while a result word is pending.");

   a_none_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_last_victim && rsp_victim_id == '0 &&
      rsp_victim_score == '0 && rsp_victim_pages == '0)
      else $error("Malformed no-victim marker.");

   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_candidate |=> !req_ready)
      else $error("Input ready right after the final candidate.");

endmodule

bind oom_victim_selector_core oomvs_checker u_oomvs_checker (.*);
